// ----- hw/rtl/cna_pkg.sv -----
// ----------------------------------------------------------------------------
// cna_pkg
// Shared types, codes and helpers of the complex arithmetic unit: payload
// structs, command and status codes, the stage record of the iteration chain.
// ----------------------------------------------------------------------------
package cna_pkg;

    // one quotient bit and one root bit per iteration stage
    localparam int STEPS = 32;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_EQ  = 3'd4;
    localparam logic [2:0] CMD_EQR = 3'd5;
    localparam logic [2:0] CMD_MOD = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [15:0] TOL_RESET = 16'd1;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_alu_in;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               is_equal;
        logic [1:0]         status;
    } t_alu_out;

    // record carried through the divide / square root chain
    typedef struct packed {
        logic               valid;
        logic [2:0]         cmd;
        logic               div0;
        logic               sat;
        logic               is_equal;
        logic signed [31:0] fix_re;
        logic signed [31:0] fix_im;
        logic               neg_re;
        logic               neg_im;
        logic               ovf_re;
        logic               ovf_im;
        logic [63:0]        den;
        logic [63:0]        rem_re;
        logic [63:0]        rem_im;
        logic [31:0]        lo_re;
        logic [31:0]        lo_im;
        logic [31:0]        q_re;
        logic [31:0]        q_im;
        logic [63:0]        sq_in;
        logic [31:0]        root;
        logic [35:0]        srem;
    } t_iter;

    // clamp a wide signed value to 32 bits; MSB of the result flags a clamp
    function automatic logic [32:0] sat65(input logic signed [64:0] v);
        logic [32:0] r;
        if ((&v[64:31]) || (~|v[64:31])) begin
            r = {1'b0, v[31:0]};
        end else begin
            r = {1'b1, v[64] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/cna_front.sv -----
// ----------------------------------------------------------------------------
// cna_front
// Front stages: capture the transfer, form the products, combine them into
// numerators and denominator, then prepare the divide and root chain.
// ----------------------------------------------------------------------------
module cna_front
    import cna_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_alu_in     i_in,
    input  logic [15:0] i_tol,
    output t_iter       o_it
);

    // stage 0: input capture
    logic    r_v0;
    t_alu_in r_in0;

    // stage 1: products
    logic               r_v1;
    t_alu_in            r_in1;
    logic signed [63:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri, r_sq1, r_sq2;
    logic signed [31:0] n_x1, n_x2;

    // stage 2: sums
    logic               r_v2;
    logic [2:0]         r_cmd2;
    logic signed [64:0] r_num_re, r_num_im;
    logic [63:0]        r_den;
    logic signed [31:0] r_fix_re, r_fix_im;
    logic               r_sat2, r_eq2;

    logic signed [64:0] n_rr, n_ii, n_ir, n_ri;
    logic signed [32:0] n_s_re, n_s_im, n_d_re, n_d_im;
    logic [32:0]        n_m_re, n_m_im, n_sat_re, n_sat_im;
    logic               n_c_re, n_c_im;
    logic signed [31:0] n_fix_re, n_fix_im;
    logic               n_sat2, n_eq2;

    // stage 3: preparation
    t_iter              r_it, n_it;
    logic signed [64:0] n_sh_re, n_sh_im;
    logic [32:0]        n_mr, n_mi;
    logic [64:0]        n_ab_re, n_ab_im;

    // hold the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
        end
        r_in0 <= i_in;
    end

    // pick squared operands: modulus squares a, divide squares b
    always_comb begin
        n_x1 = (r_in0.command == CMD_MOD) ? r_in0.a_re : r_in0.b_re;
        n_x2 = (r_in0.command == CMD_MOD) ? r_in0.a_im : r_in0.b_im;
    end

    // multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
        r_in1  <= r_in0;
        r_p_rr <= 64'(r_in0.a_re * r_in0.b_re);
        r_p_ii <= 64'(r_in0.a_im * r_in0.b_im);
        r_p_ir <= 64'(r_in0.a_im * r_in0.b_re);
        r_p_ri <= 64'(r_in0.a_re * r_in0.b_im);
        r_sq1  <= 64'(n_x1 * n_x1);
        r_sq2  <= 64'(n_x2 * n_x2);
    end

    // add, subtract and compare on the raw operands
    always_comb begin
        n_rr = {r_p_rr[63], r_p_rr};
        n_ii = {r_p_ii[63], r_p_ii};
        n_ir = {r_p_ir[63], r_p_ir};
        n_ri = {r_p_ri[63], r_p_ri};
        if (r_in1.command == CMD_SUB) begin
            n_s_re = {r_in1.a_re[31], r_in1.a_re} - {r_in1.b_re[31], r_in1.b_re};
            n_s_im = {r_in1.a_im[31], r_in1.a_im} - {r_in1.b_im[31], r_in1.b_im};
        end else begin
            n_s_re = {r_in1.a_re[31], r_in1.a_re} + {r_in1.b_re[31], r_in1.b_re};
            n_s_im = {r_in1.a_im[31], r_in1.a_im} + {r_in1.b_im[31], r_in1.b_im};
        end
        n_sat_re = sat65({{32{n_s_re[32]}}, n_s_re});
        n_sat_im = sat65({{32{n_s_im[32]}}, n_s_im});
        n_d_re = {r_in1.a_re[31], r_in1.a_re} - {r_in1.b_re[31], r_in1.b_re};
        n_d_im = {r_in1.a_im[31], r_in1.a_im} - {r_in1.b_im[31], r_in1.b_im};
        n_m_re = n_d_re[32] ? 33'(-n_d_re) : 33'(n_d_re);
        n_m_im = n_d_im[32] ? 33'(-n_d_im) : 33'(n_d_im);
        n_c_re = n_m_re < {17'd0, i_tol};
        n_c_im = n_m_im < {17'd0, i_tol};

        // select the fixed result and compare flag by command
        n_fix_re = '0;
        n_fix_im = '0;
        n_sat2   = 1'b0;
        n_eq2    = 1'b0;
        case (r_in1.command)
            CMD_ADD, CMD_SUB: begin
                n_fix_re = n_sat_re[31:0];
                n_fix_im = n_sat_im[31:0];
                n_sat2   = n_sat_re[32] | n_sat_im[32];
            end
            CMD_EQ:  n_eq2 = n_c_re & n_c_im;
            CMD_EQR: n_eq2 = n_c_re;
            default: ;
        endcase
    end

    // combine products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_cmd2 <= r_in1.command;
        r_den  <= 64'(r_sq1) + 64'(r_sq2);
        if (r_in1.command == CMD_MUL) begin
            r_num_re <= n_rr - n_ii;
            r_num_im <= n_ir + n_ri;
        end else begin
            r_num_re <= n_rr + n_ii;
            r_num_im <= n_ir - n_ri;
        end
        r_fix_re <= n_fix_re;
        r_fix_im <= n_fix_im;
        r_sat2   <= n_sat2;
        r_eq2    <= n_eq2;
    end

    // rescale products, take magnitudes and seed the chain
    always_comb begin
        n_sh_re = r_num_re >>> 16;
        n_sh_im = r_num_im >>> 16;
        n_mr    = sat65(n_sh_re);
        n_mi    = sat65(n_sh_im);
        n_ab_re = r_num_re[64] ? 65'(-r_num_re) : 65'(r_num_re);
        n_ab_im = r_num_im[64] ? 65'(-r_num_im) : 65'(r_num_im);

        n_it          = '0;
        n_it.valid    = r_v2;
        n_it.cmd      = r_cmd2;
        n_it.is_equal = r_eq2;
        n_it.fix_re   = r_fix_re;
        n_it.fix_im   = r_fix_im;
        n_it.sat      = r_sat2;
        if (r_cmd2 == CMD_MUL) begin
            n_it.fix_re = n_mr[31:0];
            n_it.fix_im = n_mi[31:0];
            n_it.sat    = n_mr[32] | n_mi[32];
        end
        n_it.div0   = (r_cmd2 == CMD_DIV) && (r_den == 64'd0);
        n_it.den    = r_den;
        n_it.neg_re = r_num_re[64];
        n_it.neg_im = r_num_im[64];
        n_it.ovf_re = {16'd0, n_ab_re[63:0]} >= {r_den, 16'd0};
        n_it.ovf_im = {16'd0, n_ab_im[63:0]} >= {r_den, 16'd0};
        n_it.rem_re = {16'd0, n_ab_re[63:16]};
        n_it.rem_im = {16'd0, n_ab_im[63:16]};
        n_it.lo_re  = {n_ab_re[15:0], 16'd0};
        n_it.lo_im  = {n_ab_im[15:0], 16'd0};
        n_it.sq_in  = r_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it <= '0;
        end else begin
            r_it <= n_it;
        end
    end

    assign o_it = r_it;

endmodule

// ----- hw/rtl/cna_step.sv -----
// ----------------------------------------------------------------------------
// cna_step
// One stage of the chain: one restoring quotient bit for each part of the
// division and one bit of the integer square root.
// ----------------------------------------------------------------------------
module cna_step
    import cna_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_iter i_it,
    output t_iter o_it
);

    t_iter       r_it, n_it;
    logic [64:0] n_r_re, n_r_im, n_dv;
    logic        n_ge_re, n_ge_im, n_ge_sq;
    logic [35:0] n_rr, n_t;

    always_comb begin
        n_it = i_it;

        // divide: shift in next dividend bit, subtract when it fits
        n_dv    = {1'b0, i_it.den};
        n_r_re  = {i_it.rem_re, i_it.lo_re[31]};
        n_r_im  = {i_it.rem_im, i_it.lo_im[31]};
        n_ge_re = n_r_re >= n_dv;
        n_ge_im = n_r_im >= n_dv;
        n_it.rem_re = n_ge_re ? 64'(n_r_re - n_dv) : n_r_re[63:0];
        n_it.rem_im = n_ge_im ? 64'(n_r_im - n_dv) : n_r_im[63:0];
        n_it.q_re   = {i_it.q_re[30:0], n_ge_re};
        n_it.q_im   = {i_it.q_im[30:0], n_ge_im};
        n_it.lo_re  = {i_it.lo_re[30:0], 1'b0};
        n_it.lo_im  = {i_it.lo_im[30:0], 1'b0};

        // root: bring down two radicand bits, try root*4+1
        n_rr    = {i_it.srem[33:0], i_it.sq_in[63:62]};
        n_t     = {2'b00, i_it.root, 2'b01};
        n_ge_sq = n_rr >= n_t;
        n_it.srem  = n_ge_sq ? (n_rr - n_t) : n_rr;
        n_it.root  = {i_it.root[30:0], n_ge_sq};
        n_it.sq_in = {i_it.sq_in[61:0], 2'b00};
    end

    // advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it <= '0;
        end else begin
            r_it <= n_it;
        end
    end

    assign o_it = r_it;

endmodule

// ----- hw/rtl/cna_back.sv -----
// ----------------------------------------------------------------------------
// cna_back
// Output stage: sign and clamp the quotients and root, select the result by
// command and drive the result strobe.
// ----------------------------------------------------------------------------
module cna_back
    import cna_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_iter    i_it,
    output logic     o_valid,
    output t_alu_out o_res
);

    logic        r_valid;
    t_alu_out    r_res, n_res;
    logic [32:0] n_m_re, n_m_im, n_q_re, n_q_im, n_root;
    logic        n_sat;

    always_comb begin
        // big quotients clamp either way; fold them to 2^32
        n_m_re = i_it.ovf_re ? 33'h1_0000_0000 : {1'b0, i_it.q_re};
        n_m_im = i_it.ovf_im ? 33'h1_0000_0000 : {1'b0, i_it.q_im};
        n_q_re = sat65(i_it.neg_re ? -{32'd0, n_m_re} : {32'd0, n_m_re});
        n_q_im = sat65(i_it.neg_im ? -{32'd0, n_m_im} : {32'd0, n_m_im});
        n_root = sat65({33'd0, i_it.root});

        n_res          = '0;
        n_res.is_equal = i_it.is_equal;
        n_sat          = 1'b0;
        case (i_it.cmd)
            CMD_ADD, CMD_SUB, CMD_MUL: begin
                n_res.res_re = i_it.fix_re;
                n_res.res_im = i_it.fix_im;
                n_sat        = i_it.sat;
            end
            CMD_DIV: begin
                if (!i_it.div0) begin
                    n_res.res_re = n_q_re[31:0];
                    n_res.res_im = n_q_im[31:0];
                    n_sat        = n_q_re[32] | n_q_im[32];
                end
            end
            CMD_MOD: begin
                n_res.res_re = n_root[31:0];
                n_sat        = n_root[32];
            end
            default: ;
        endcase
        if (i_it.div0) begin
            n_res.status = ST_DIV0;
        end else if (n_sat) begin
            n_res.status = ST_SAT;
        end else begin
            n_res.status = ST_OK;
        end
    end

    // register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_it.valid;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- hw/rtl/complex_number_alu.sv -----
// ----------------------------------------------------------------------------
// complex_number_alu
// Complex arithmetic unit on signed Q16.16 operands: add, subtract, multiply,
// divide, compare within a tolerance and modulus.
//
// Usage:
//  - Command channel: drive i_cmd and raise i_start; the command transfers
//    at each rising edge with i_start high and o_busy low. o_busy is high
//    only while reset is asserted, so one command can transfer every cycle.
//  - Result channel: o_valid strobes for one cycle with o_res; the receiver
//    must take it then. One result per command, in command order.
//  - Throughput one item per cycle. The depth is set by the 32-stage chain
//    that forms one quotient bit and one root bit per stage, plus capture,
//    multiply, sum, prepare and output stages.
//  - Config: i_cfg_we writes i_cfg_wdata to the equality tolerance; write it
//    only while no command is in flight.
//  - Reset (synchronous, active low) empties the pipeline and sets the
//    tolerance to 1.
// ----------------------------------------------------------------------------
module complex_number_alu
    import cna_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_alu_in     i_cmd,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_valid,
    output t_alu_out    o_res
);

    logic [15:0] r_tol;
    t_iter       w_it [0:STEPS];

    assign o_busy = !i_rst_n;

    // hold the tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    cna_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_in    (i_cmd),
        .i_tol   (r_tol),
        .o_it    (w_it[0])
    );

    // divide and root chain
    for (genvar g = 0; g < STEPS; g++) begin : g_step
        cna_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_it    (w_it[g]),
            .o_it    (w_it[g+1])
        );
    end

    cna_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_it    (w_it[STEPS]),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // end of chain feeds the result strobe in the following cycle
    a_chain_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_it[STEPS].valid |=> o_valid)
        else $error("chain item did not reach output");

    // a zero divisor carries zero parts and no equality
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.status == ST_DIV0) |->
        (o_res.res_re == 32'sd0 && o_res.res_im == 32'sd0 && !o_res.is_equal))
        else $error("divide by zero result not cleared");

    // an equality hit comes only from a compare: zero parts, status ok
    a_equal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.is_equal) |->
        (o_res.res_re == 32'sd0 && o_res.res_im == 32'sd0 && o_res.status == ST_OK))
        else $error("compare result carries data");

endmodule

// ----- tb/complex_number_alu_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_number_alu_tb
// Drives commands into the complex arithmetic unit, predicts every result in
// exact wide arithmetic, and checks each result strobe in order against the
// prediction. The tolerance register is changed between phases.
// ----------------------------------------------------------------------------
module complex_number_alu_tb;
    import cna_pkg::*;

    localparam logic [2:0] CMD_NONE  = 3'd7;
    localparam int         FLUSH_CYC = 45;
    localparam int         MAX_CYC   = 400000;
    localparam logic signed [31:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_alu_in     i_cmd;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        o_valid;
    t_alu_out    o_res;

    int unsigned cycle_cnt;
    int unsigned idle_pct;

    // ------------------------------------------------------------------------
    // Predicts results of accepted commands and checks result transfers
    // ------------------------------------------------------------------------
    class alu_scoreboard;
        logic [15:0] tolerance;
        t_alu_out    pending[$];
        int unsigned errors;

        function new();
            tolerance = TOL_RESET;
            errors    = 0;
        endfunction

        function void report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endfunction

        // clamp to 32 bits, flag a clamp
        function logic [31:0] clamp(input logic signed [83:0] v, inout logic sat);
            if (v > 84'(QMAX)) begin
                sat = 1'b1;
                return QMAX;
            end
            if (v < 84'(QMIN)) begin
                sat = 1'b1;
                return QMIN;
            end
            return v[31:0];
        endfunction

        function logic [31:0] root_floor(input logic [63:0] s);
            logic [63:0] r, b, rem;
            r   = '0;
            b   = 64'h4000_0000_0000_0000;
            rem = s;
            for (int k = 0; k < 32; k++) begin
                if (rem >= r + b) begin
                    rem = rem - (r + b);
                    r   = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r[31:0];
        endfunction

        function logic near(input logic signed [31:0] x, input logic signed [31:0] y);
            logic signed [32:0] d;
            d = 33'(x) - 33'(y);
            if (d < 0) d = -d;
            return d < 33'(tolerance);
        endfunction

        // signed quotient (num * 2^16) / den, truncated toward zero
        function logic signed [83:0] scaled_quot(input logic signed [65:0] num,
                                                 input logic [63:0] den);
            logic [65:0]        mag;
            logic [81:0]        q;
            logic signed [83:0] v;
            mag = (num < 0) ? 66'(-num) : 66'(num);
            q   = {mag, 16'h0} / 82'(den);
            v   = {2'b00, q};
            return (num < 0) ? -v : v;
        endfunction

        function void note_command(input t_alu_in c);
            t_alu_out           e;
            logic               sat;
            logic signed [65:0] ar, ai, br, bi, nre, nim;
            logic [63:0]        den;
            ar = c.a_re;
            ai = c.a_im;
            br = c.b_re;
            bi = c.b_im;
            e   = '0;
            sat = 1'b0;
            case (c.command)
                CMD_ADD: begin
                    e.res_re = clamp(ar + br, sat);
                    e.res_im = clamp(ai + bi, sat);
                end
                CMD_SUB: begin
                    e.res_re = clamp(ar - br, sat);
                    e.res_im = clamp(ai - bi, sat);
                end
                CMD_MUL: begin
                    nre = ar * br - ai * bi;
                    nim = ai * br + ar * bi;
                    e.res_re = clamp(nre >>> 16, sat);
                    e.res_im = clamp(nim >>> 16, sat);
                end
                CMD_DIV: begin
                    den = 64'(br * br + bi * bi);
                    if (den == 0) begin
                        e.status = ST_DIV0;
                    end else begin
                        nre = ar * br + ai * bi;
                        nim = ai * br - ar * bi;
                        e.res_re = clamp(scaled_quot(nre, den), sat);
                        e.res_im = clamp(scaled_quot(nim, den), sat);
                    end
                end
                CMD_EQ:  e.is_equal = near(c.a_re, c.b_re) && near(c.a_im, c.b_im);
                CMD_EQR: e.is_equal = near(c.a_re, c.b_re);
                CMD_MOD: begin
                    den = 64'(ar * ar + ai * ai);
                    e.res_re = clamp({52'h0, root_floor(den)}, sat);
                end
                default: ;
            endcase
            if (sat && e.status == ST_OK) e.status = ST_SAT;
            pending.push_back(e);
        endfunction

        function void check_result(input t_alu_out r);
            t_alu_out e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h", r));
                return;
            end
            e = pending.pop_front();
            if (r.res_re !== e.res_re)
                report($sformatf("res_re got %h want %h", r.res_re, e.res_re));
            if (r.res_im !== e.res_im)
                report($sformatf("res_im got %h want %h", r.res_im, e.res_im));
            if (r.is_equal !== e.is_equal)
                report($sformatf("is_equal got %b want %b", r.is_equal, e.is_equal));
            if (r.status !== e.status)
                report($sformatf("status got %0d want %0d", r.status, e.status));
        endfunction
    endclass

    alu_scoreboard sb;

    complex_number_alu u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // note command transfers and check result transfers
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) sb.note_command(i_cmd);
        if (i_rst_n && o_valid) sb.check_result(o_res);
    end

    // bound the run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYC) begin
            $display("complex_number_alu_tb: done, errors");
            $finish;
        end
    end

    // hold one command until it transfers, then idle for a random share of cycles
    task automatic send(input t_alu_in c);
        i_cmd   <= c;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_op(input logic [2:0] op, input logic [31:0] ar,
                           input logic [31:0] ai, input logic [31:0] br,
                           input logic [31:0] bi);
        t_alu_in c;
        c.command = op;
        c.a_re    = ar;
        c.a_im    = ai;
        c.b_re    = br;
        c.b_im    = bi;
        send(c);
    endtask

    // drop start and wait until the pipeline is empty
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYC) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.tolerance = v;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return QMIN;
            1:       return QMAX;
            2:       return 32'h0;
            3, 4:    return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            default: return $urandom();
        endcase
    endfunction

    // random commands; compares often use nearby operands
    task automatic send_random(input int n);
        logic [2:0]  op;
        logic [31:0] ar, ai, br, bi;
        for (int k = 0; k < n; k++) begin
            op = 3'($urandom_range(0, 7));
            ar = pick_operand();
            ai = pick_operand();
            br = pick_operand();
            bi = pick_operand();
            if ((op == CMD_EQ || op == CMD_EQR) && $urandom_range(0, 1)) begin
                br = ar + 32'($signed($urandom_range(0, 8)) - 4);
                bi = ai + 32'($signed($urandom_range(0, 80000)) - 40000);
            end
            if (op == CMD_DIV && $urandom_range(0, 9) == 0) begin
                br = '0;
                bi = '0;
            end
            send_op(op, ar, ai, br, bi);
        end
    endtask

    initial begin
        sb          = new();
        cycle_cnt   = 0;
        idle_pct    = 0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_cmd       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, divide by zero, saturation
        send_op(CMD_ADD, QMAX, QMIN, QMAX, QMIN);
        send_op(CMD_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_8000, 32'h0);
        send_op(CMD_SUB, QMIN, QMAX, QMAX, QMIN);
        send_op(CMD_SUB, QMIN, 32'h5, 32'h0, 32'h5);
        send_op(CMD_MUL, QMIN, QMIN, QMIN, QMIN);
        send_op(CMD_MUL, QMAX, QMIN, QMAX, QMAX);
        send_op(CMD_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
        send_op(CMD_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0, 32'h0);
        send_op(CMD_DIV, QMAX, QMIN, 32'h0000_0001, 32'h0);
        send_op(CMD_DIV, QMIN, QMIN, QMIN, QMIN);
        send_op(CMD_DIV, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
        send_op(CMD_EQ, 32'h1234, 32'h5678, 32'h1234, 32'h5678);
        send_op(CMD_EQ, 32'h1234, 32'h5678, 32'h1235, 32'h5678);
        send_op(CMD_EQ, QMIN, QMAX, QMAX, QMIN);
        send_op(CMD_EQR, 32'h7, 32'h99, 32'h7, 32'h3);
        send_op(CMD_EQR, QMAX, 32'h0, QMIN, 32'h0);
        send_op(CMD_MOD, QMIN, QMIN, 32'h0, 32'h0);
        send_op(CMD_MOD, 32'h0003_0000, 32'h0004_0000, 32'h1, 32'h1);
        send_op(CMD_MOD, 32'h0, 32'h0, QMAX, QMAX);
        send_op(CMD_NONE, QMAX, QMIN, QMAX, QMIN);
        drain();

        // zero tolerance: no compare ever matches
        write_tolerance(16'd0);
        send_op(CMD_EQ, 32'h42, 32'h42, 32'h42, 32'h42);
        send_op(CMD_EQR, 32'h42, 32'h0, 32'h42, 32'h0);
        idle_pct = 38;
        send_random(400);
        drain();

        write_tolerance(16'hFFFF);
        idle_pct = 81;
        send_random(400);
        drain();

        write_tolerance(16'($urandom_range(2, 65534)));
        idle_pct = 0;
        send_random(400);
        drain();

        if (sb.errors == 0) begin
            $display("complex_number_alu_tb: done, clean");
        end else begin
            $display("complex_number_alu_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- complex_number_alu.f -----
hw/rtl/cna_pkg.sv
hw/rtl/cna_front.sv
hw/rtl/cna_step.sv
hw/rtl/cna_back.sv
hw/rtl/complex_number_alu.sv
tb/complex_number_alu_tb.sv
